[rtl/spkt_pkg.sv]
`timescale 1ns / 1ps

package spkt_pkg;

    localparam int KEY_W       = 21;
    localparam int PAIR_W      = 2 * KEY_W;
    localparam int VAL_W       = 16;
    localparam int ENTRY_W     = PAIR_W + VAL_W;
    localparam int CNT_OUT_W   = 9;
    localparam int OP_W        = 2;
    localparam int S_TDATA_W   = 64;
    localparam int M_TDATA_W   = 32;
    localparam int M_PAD_W     = M_TDATA_W - (VAL_W + 2 + CNT_OUT_W);
    localparam int S_PAD_W     = S_TDATA_W - ENTRY_W;

    typedef logic [OP_W-1:0] op_t;

    localparam op_t OP_LOOKUP = 2'd0;
    localparam op_t OP_SET    = 2'd1;
    localparam op_t OP_CLEAR  = 2'd2;
    localparam op_t OP_NOP    = 2'd3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_RESOLVE,
        ST_SHIFT,
        ST_WRITE,
        ST_DONE
    } state_t;

endpackage

[rtl/sorted_pair_key_table.sv]
`timescale 1ns / 1ps

// sorted pair key table
// keeps up to TABLE_DEPTH entries {first codepoint, second codepoint, value}
// in one block ram, sorted ascending by first then second codepoint
//
// input stream: s_axis_tuser carries the operation (lookup, set, clear),
// s_axis_tdata the key pair and the value to set
// result stream: one word per accepted input word with the stored value,
// found and table_full flags and the entry count after the operation
//
// a lookup or an update runs a binary search, one ram read per step; an
// insert then moves each entry from the new slot upward by one slot and
// writes the new entry there; clear and unused codes skip the search
// one item is worked on at a time; the single ram read port sets the pace
//
// reset clears the entry count, the state and the output valid; ram contents
// beyond the count are never used, so the ram needs no clearing pass
// a finished word waits in the output register while the receiver stalls;
// the next input word is taken meanwhile, and its result holds until the
// output register frees up
module sorted_pair_key_table #(
    parameter int TABLE_DEPTH = 256
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // first_codepoint [20:0], second_codepoint [41:21], set_value [57:42], zero pad
    input  logic [spkt_pkg::S_TDATA_W-1:0] s_axis_tdata,
    // operation [1:0]
    input  logic [spkt_pkg::OP_W-1:0]      s_axis_tuser,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // read_value [15:0], found [16], table_full [17], entry_count [26:18], zero pad
    output logic [spkt_pkg::M_TDATA_W-1:0] m_axis_tdata
);
    import spkt_pkg::*;

    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(TABLE_DEPTH);

    // entry ram: simple dual port, registered read
    logic [ENTRY_W-1:0] mem [TABLE_DEPTH];
    logic [ENTRY_W-1:0] rdata_reg;
    logic               mem_we;
    logic [IDX_W-1:0]   mem_waddr;
    logic [ENTRY_W-1:0] mem_wdata;
    logic [IDX_W-1:0]   mem_raddr;

    state_t state_reg, state_next;

    op_t                op_reg, op_next;
    logic [PAIR_W-1:0]  key_reg, key_next;
    logic [VAL_W-1:0]   val_reg, val_next;
    logic [CNT_W-1:0]   count_reg, count_next;

    // search window and the last entry seen at the upper bound
    logic [CNT_W-1:0]   lo_reg, lo_next;
    logic [CNT_W-1:0]   hi_reg, hi_next;
    logic [CNT_W-1:0]   mid_reg, mid_next;
    logic               rd_pend_reg, rd_pend_next;
    logic               hi_set_reg, hi_set_next;
    logic [ENTRY_W-1:0] hi_ent_reg, hi_ent_next;

    // shift pipeline
    logic [CNT_W-1:0]   shift_ptr_reg, shift_ptr_next;
    logic               wr_pend_reg, wr_pend_next;
    logic [CNT_W-1:0]   wr_addr_reg, wr_addr_next;

    // result waiting for the output register
    logic [VAL_W-1:0]   res_value_reg, res_value_next;
    logic               res_found_reg, res_found_next;
    logic               res_full_reg, res_full_next;

    logic                 m_valid_reg, m_valid_next;
    logic [M_TDATA_W-1:0] m_data_reg, m_data_next;

    logic                 s_hs;
    logic                 out_free;
    logic                 less;
    logic [CNT_W-1:0]     lo_c, hi_c, mid_c;
    logic                 hi_set_c;
    logic [ENTRY_W-1:0]   hi_ent_c;
    logic                 search_done;
    logic                 hit;
    logic [CNT_W+CNT_OUT_W-1:0] cnt_wide;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign s_hs          = s_axis_tvalid && s_axis_tready;
    assign out_free      = !m_valid_reg || m_axis_tready;
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

    // one search step: narrow the window with the entry read last cycle
    assign less = rdata_reg[ENTRY_W-1:VAL_W] < key_reg;

    always_comb begin
        lo_c     = lo_reg;
        hi_c     = hi_reg;
        hi_set_c = hi_set_reg;
        hi_ent_c = hi_ent_reg;
        if (rd_pend_reg) begin
            if (less) begin
                lo_c = mid_reg + CNT_W'(1);
            end else begin
                hi_c     = mid_reg;
                hi_set_c = 1'b1;
                hi_ent_c = rdata_reg;
            end
        end
    end

    assign mid_c       = lo_c + ((hi_c - lo_c) >> 1);
    assign search_done = !(lo_c < hi_c);
    assign hit         = hi_set_reg && (hi_ent_reg[ENTRY_W-1:VAL_W] == key_reg);
    assign cnt_wide    = {{CNT_OUT_W{1'b0}}, count_reg};

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_hs) begin
                    if (s_axis_tuser == OP_LOOKUP || s_axis_tuser == OP_SET) begin
                        state_next = ST_SEARCH;
                    end else begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_SEARCH: begin
                if (search_done) begin
                    state_next = ST_RESOLVE;
                end
            end
            ST_RESOLVE: begin
                if (op_reg == OP_SET && !hit && count_reg != DEPTH_CNT) begin
                    state_next = ST_SHIFT;
                end else begin
                    state_next = ST_DONE;
                end
            end
            ST_SHIFT: begin
                if (shift_ptr_reg == lo_reg && !wr_pend_reg) begin
                    state_next = ST_WRITE;
                end
            end
            ST_WRITE: begin
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // datapath and ram control
    always_comb begin
        op_next        = op_reg;
        key_next       = key_reg;
        val_next       = val_reg;
        count_next     = count_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        mid_next       = mid_reg;
        rd_pend_next   = 1'b0;
        hi_set_next    = hi_set_reg;
        hi_ent_next    = hi_ent_reg;
        shift_ptr_next = shift_ptr_reg;
        wr_pend_next   = 1'b0;
        wr_addr_next   = wr_addr_reg;
        res_value_next = res_value_reg;
        res_found_next = res_found_reg;
        res_full_next  = res_full_reg;
        m_valid_next   = m_valid_reg && !m_axis_tready;
        m_data_next    = m_data_reg;
        mem_we         = 1'b0;
        mem_waddr      = lo_reg[IDX_W-1:0];
        mem_wdata      = {key_reg, val_reg};
        mem_raddr      = mid_c[IDX_W-1:0];

        case (state_reg)
            ST_IDLE: begin
                if (s_hs) begin
                    op_next        = s_axis_tuser;
                    key_next       = {s_axis_tdata[KEY_W-1:0], s_axis_tdata[PAIR_W-1:KEY_W]};
                    val_next       = s_axis_tdata[ENTRY_W-1:PAIR_W];
                    lo_next        = '0;
                    hi_next        = count_reg;
                    hi_set_next    = 1'b0;
                    res_value_next = '0;
                    res_found_next = 1'b0;
                    res_full_next  = 1'b0;
                    if (s_axis_tuser == OP_CLEAR) begin
                        count_next = '0;
                    end
                end
            end
            ST_SEARCH: begin
                lo_next     = lo_c;
                hi_next     = hi_c;
                hi_set_next = hi_set_c;
                hi_ent_next = hi_ent_c;
                if (!search_done) begin
                    mid_next     = mid_c;
                    rd_pend_next = 1'b1;
                end
            end
            ST_RESOLVE: begin
                res_found_next = hit;
                if (op_reg == OP_LOOKUP) begin
                    if (hit) begin
                        res_value_next = hi_ent_reg[VAL_W-1:0];
                    end
                end else if (hit) begin
                    mem_we = 1'b1;
                end else if (count_reg == DEPTH_CNT) begin
                    res_full_next = 1'b1;
                end else begin
                    shift_ptr_next = count_reg;
                end
            end
            ST_SHIFT: begin
                // read entry i-1 while the one read last cycle, entry i, lands at i+1
                mem_raddr = shift_ptr_next[IDX_W-1:0];
                if (wr_pend_reg) begin
                    mem_we    = 1'b1;
                    mem_waddr = wr_addr_reg[IDX_W-1:0];
                    mem_wdata = rdata_reg;
                end
                if (shift_ptr_reg != lo_reg) begin
                    shift_ptr_next = shift_ptr_reg - CNT_W'(1);
                    mem_raddr      = shift_ptr_next[IDX_W-1:0];
                    wr_pend_next   = 1'b1;
                    wr_addr_next   = shift_ptr_reg;
                end
            end
            ST_WRITE: begin
                mem_we     = 1'b1;
                count_next = count_reg + CNT_W'(1);
            end
            ST_DONE: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_data_next  = {{M_PAD_W{1'b0}}, cnt_wide[CNT_OUT_W-1:0],
                                    res_full_reg, res_found_reg, res_value_reg};
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        rdata_reg <= mem[mem_raddr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            rd_pend_reg <= 1'b0;
            wr_pend_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            rd_pend_reg <= rd_pend_next;
            wr_pend_reg <= wr_pend_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg        <= op_next;
        key_reg       <= key_next;
        val_reg       <= val_next;
        lo_reg        <= lo_next;
        hi_reg        <= hi_next;
        mid_reg       <= mid_next;
        hi_set_reg    <= hi_set_next;
        hi_ent_reg    <= hi_ent_next;
        shift_ptr_reg <= shift_ptr_next;
        wr_addr_reg   <= wr_addr_next;
        res_value_reg <= res_value_next;
        res_found_reg <= res_found_next;
        res_full_reg  <= res_full_next;
        m_data_reg    <= m_data_next;
    end

endmodule

[rtl/spkt_checker.sv]
`timescale 1ns / 1ps

module spkt_checker #(
    parameter int TABLE_DEPTH = 256
) (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_axis_tvalid,
    input logic                           s_axis_tready,
    input logic                           m_axis_tvalid,
    input logic                           m_axis_tready,
    input logic [spkt_pkg::M_TDATA_W-1:0] m_axis_tdata
);
    import spkt_pkg::*;

    // stalled result word holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result word changed while stalled");

    // one item at a time: ready drops after an accepted word
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input taken while busy");

    // a refused insert reports no hit and no value
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tdata[17] |-> !m_axis_tdata[16] && m_axis_tdata[15:0] == 16'd0)
        else $error("table_full with found or value");

    // a value only comes with a hit
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tdata[15:0] != 16'd0 |-> m_axis_tdata[16])
        else $error("value without found");

    // count never passes the depth
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && TABLE_DEPTH < 512 |-> 32'(m_axis_tdata[26:18]) <= TABLE_DEPTH)
        else $error("entry_count above depth");

endmodule

bind sorted_pair_key_table spkt_checker #(
    .TABLE_DEPTH(TABLE_DEPTH)
) u_spkt_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

[test/pair_table_checker.sv]
`timescale 1ns / 1ps

// watches both streams, keeps its own copy of the sorted table and compares
// every result word against the oldest prediction
module pair_table_checker #(
    parameter int TABLE_DEPTH = 256
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_axis_tvalid,
    input  logic                           s_axis_tready,
    // first_codepoint [20:0], second_codepoint [41:21], set_value [57:42], zero pad
    input  logic [spkt_pkg::S_TDATA_W-1:0] s_axis_tdata,
    // operation [1:0]
    input  logic [spkt_pkg::OP_W-1:0]      s_axis_tuser,
    input  logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // read_value [15:0], found [16], table_full [17], entry_count [26:18], zero pad
    input  logic [spkt_pkg::M_TDATA_W-1:0] m_axis_tdata,
    output int                             mismatch_count,
    output int                             pending_count
);
    import spkt_pkg::*;

    typedef struct packed {
        logic [CNT_OUT_W-1:0] entry_count;
        logic                 table_full;
        logic                 found;
        logic [VAL_W-1:0]     read_value;
    } lookup_result_t;

    logic [PAIR_W-1:0] pair_keys [TABLE_DEPTH];
    logic [VAL_W-1:0]  pair_vals [TABLE_DEPTH];
    int                stored_pairs = 0;
    lookup_result_t    predicted_results [$];

    // binary search for the first slot not below the key, then read the value,
    // update, insert with shift or refuse when full; or clear
    function automatic lookup_result_t apply_table_op(op_t op, logic [PAIR_W-1:0] key,
                                                      logic [VAL_W-1:0] val);
        lookup_result_t r;
        int lo;
        int hi;
        int mid;
        int i;
        bit hit;
        r = '0;
        if (op == OP_LOOKUP || op == OP_SET) begin
            lo = 0;
            hi = stored_pairs;
            while (lo < hi) begin
                mid = lo + (hi - lo) / 2;
                if (pair_keys[mid] < key) lo = mid + 1;
                else hi = mid;
            end
            hit = (lo < stored_pairs) && (pair_keys[lo] == key);
            if (op == OP_LOOKUP) begin
                if (hit) begin
                    r.found = 1'b1;
                    r.read_value = pair_vals[lo];
                end
            end else if (hit) begin
                r.found = 1'b1;
                pair_vals[lo] = val;
            end else if (stored_pairs >= TABLE_DEPTH) begin
                r.table_full = 1'b1;
            end else begin
                for (i = stored_pairs; i > lo; i--) begin
                    pair_keys[i] = pair_keys[i-1];
                    pair_vals[i] = pair_vals[i-1];
                end
                pair_keys[lo] = key;
                pair_vals[lo] = val;
                stored_pairs++;
            end
        end else if (op == OP_CLEAR) begin
            stored_pairs = 0;
        end
        r.entry_count = stored_pairs[CNT_OUT_W-1:0];
        return r;
    endfunction

    task automatic flag_mismatch(string what, int want, int got);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("mismatch %0d at %0t: %s expected %0d, got %0d",
                     mismatch_count, $realtime, what, want, got);
    endtask

    always @(posedge aclk) begin
        lookup_result_t got;
        lookup_result_t want;
        lookup_result_t pred;
        if (!aresetn) begin
            stored_pairs = 0;
            predicted_results.delete();
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                got = m_axis_tdata[$bits(lookup_result_t)-1:0];
                if (predicted_results.size() == 0) begin
                    flag_mismatch("unexpected result word, entry_count", -1, got.entry_count);
                end else begin
                    want = predicted_results.pop_front();
                    if (got.read_value !== want.read_value)
                        flag_mismatch("read_value", $signed(want.read_value),
                                      $signed(got.read_value));
                    if (got.found !== want.found)
                        flag_mismatch("found", want.found, got.found);
                    if (got.table_full !== want.table_full)
                        flag_mismatch("table_full", want.table_full, got.table_full);
                    if (got.entry_count !== want.entry_count)
                        flag_mismatch("entry_count", want.entry_count, got.entry_count);
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                pred = apply_table_op(op_t'(s_axis_tuser),
                    {s_axis_tdata[KEY_W-1:0], s_axis_tdata[PAIR_W-1:KEY_W]},
                    s_axis_tdata[ENTRY_W-1:PAIR_W]);
                predicted_results = {predicted_results, pred};
            end
        end
        pending_count = predicted_results.size();
    end

endmodule

[test/tb_sorted_pair_key_table.sv]
`timescale 1ns / 1ps

// stimulus and verdict for the sorted pair key table; the checker beside
// the block does all prediction and comparison
module tb_sorted_pair_key_table;
    import spkt_pkg::*;

    localparam int DEPTH       = 256;
    localparam int HOLD_CYCLES = 400;   // long receiver stall, fills the block
    localparam int FILL_WORDS  = 300;   // more inserts than the table holds
    localparam logic [KEY_W-1:0] CP_MAX = 21'd1114111;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    // first_codepoint [20:0], second_codepoint [41:21], set_value [57:42], zero pad
    logic [S_TDATA_W-1:0] s_axis_tdata = '0;
    // operation [1:0]
    logic [OP_W-1:0]      s_axis_tuser = OP_LOOKUP;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    // read_value [15:0], found [16], table_full [17], entry_count [26:18], zero pad
    logic [M_TDATA_W-1:0] m_axis_tdata;

    int          mismatch_count;
    int          pending_count;
    bit          quiet_tail = 1'b0;     // no idling on either side at the end
    int unsigned hold_seq = 0;          // bumped by the sender to request a hold
    int unsigned hold_seen = 0;
    int unsigned hold_left = 0;
    int unsigned rx_gap = 0;

    // small key pools so that lookups and updates actually hit
    logic [KEY_W-1:0] pool_first [8];
    logic [KEY_W-1:0] pool_second [8];
    // keys used to fill the table to the brim
    logic [KEY_W-1:0] fill_first [FILL_WORDS];
    logic [KEY_W-1:0] fill_second [FILL_WORDS];

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    sorted_pair_key_table #(
        .TABLE_DEPTH(DEPTH)
    ) uut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata)
    );

    pair_table_checker #(
        .TABLE_DEPTH(DEPTH)
    ) table_check (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .mismatch_count(mismatch_count),
        .pending_count (pending_count)
    );

    // result side: a requested hold wins, then burst gaps, else ready
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_axis_tready <= 1'b0;
            hold_left <= 0;
            rx_gap <= 0;
        end else if (hold_seq != hold_seen) begin
            hold_seen <= hold_seq;
            hold_left <= HOLD_CYCLES - 1;
            m_axis_tready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end else if (rx_gap != 0) begin
            rx_gap <= rx_gap - 1;
            m_axis_tready <= 1'b0;
        end else if (!quiet_tail && $urandom_range(0, 9) == 0) begin
            // start an idle burst of random length
            rx_gap <= $urandom_range(0, 18);
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    function automatic logic [KEY_W-1:0] rand_cp();
        return KEY_W'($urandom_range(0, 1114111));
    endfunction

    function automatic logic [VAL_W-1:0] rand_val();
        return VAL_W'($urandom_range(0, 65535));
    endfunction

    // mostly pool keys, sometimes any codepoint pair
    task automatic pick_key(output logic [KEY_W-1:0] first, output logic [KEY_W-1:0] second);
        if ($urandom_range(0, 4) == 0) begin
            first = rand_cp();
            second = rand_cp();
        end else begin
            first = pool_first[$urandom_range(0, 7)];
            second = pool_second[$urandom_range(0, 7)];
        end
    endtask

    // offer one word and return at the edge that accepts it; valid stays
    // high so back-to-back words need no second assignment in one step
    task automatic send_word(op_t op, logic [KEY_W-1:0] first, logic [KEY_W-1:0] second,
                             logic [VAL_W-1:0] value);
        if (!quiet_tail && $urandom_range(0, 9) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge aclk);
        end
        s_axis_tdata <= {{S_PAD_W{1'b0}}, value, second, first};
        s_axis_tuser <= op;
        s_axis_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_axis_tready);
    endtask

    // stop offering and wait until every predicted word has come back
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_count != 0) @(posedge aclk);
    endtask

    // random mix: lookups and sets dominate, a few clears and unused codes
    task automatic mixed_words(int n);
        int k;
        int r;
        op_t op;
        logic [KEY_W-1:0] f;
        logic [KEY_W-1:0] s;
        for (k = 0; k < n; k++) begin
            r = $urandom_range(0, 99);
            op = (r < 44) ? OP_LOOKUP : (r < 88) ? OP_SET : (r < 94) ? OP_NOP : OP_CLEAR;
            pick_key(f, s);
            send_word(op, f, s, rand_val());
        end
    endtask

    initial begin
        int i;
        int idx;
        for (i = 0; i < 8; i++) begin
            pool_first[i] = rand_cp();
            pool_second[i] = rand_cp();
        end
        pool_first[0] = '0;
        pool_second[7] = CP_MAX;
        for (i = 0; i < FILL_WORDS; i++) begin
            fill_first[i] = rand_cp();
            fill_second[i] = rand_cp();
        end

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // empty table: lookup miss, unused code, clear
        send_word(OP_LOOKUP, '0, '0, '0);
        send_word(OP_NOP, '0, '0, '0);
        send_word(OP_CLEAR, '0, '0, '0);
        // corner keys and values, inserted out of order
        send_word(OP_SET, '0, '0, 16'h8000);
        send_word(OP_SET, CP_MAX, CP_MAX, 16'h7FFF);
        send_word(OP_SET, '0, CP_MAX, 16'h0001);
        send_word(OP_SET, CP_MAX, '0, 16'hFFFF);
        send_word(OP_LOOKUP, '0, '0, '0);
        send_word(OP_LOOKUP, CP_MAX, CP_MAX, '0);
        send_word(OP_LOOKUP, '0, CP_MAX, '0);
        send_word(OP_LOOKUP, CP_MAX, '0, '0);
        // update of an existing pair keeps the count
        send_word(OP_SET, '0, '0, 16'h1234);
        send_word(OP_LOOKUP, '0, '0, 16'h5555);
        send_word(OP_LOOKUP, 21'd1, '0, '0);
        // unused code with the largest codepoints and an all-ones value
        send_word(OP_NOP, CP_MAX, CP_MAX, 16'hFFFF);
        // insert in the middle, alternating bit patterns
        send_word(OP_SET, 21'h100000, 21'h0AAAAA, 16'h5555);
        send_word(OP_LOOKUP, 21'h100000, 21'h0AAAAA, '0);
        send_word(OP_CLEAR, 21'h155555, 21'h0FFFFF, 16'hAAAA);
        send_word(OP_LOOKUP, CP_MAX, CP_MAX, '0);
        send_word(OP_SET, 21'h0AAAAA, 21'h155555, 16'h2AAA);
        wait_drained();

        // random mix; a long receiver hold partway backs up the input side
        mixed_words(100);
        hold_seq <= hold_seq + 1;
        mixed_words(60);
        wait_drained();
        mixed_words(60);

        // fill the table past its depth: the last inserts are refused
        send_word(OP_CLEAR, rand_cp(), rand_cp(), rand_val());
        for (i = 0; i < FILL_WORDS; i++)
            send_word(OP_SET, fill_first[i], fill_second[i], rand_val());

        // full table: hits, updates that need no room, refused inserts, misses
        for (i = 0; i < 40; i++) begin
            idx = $urandom_range(0, DEPTH - 1);
            case ($urandom_range(0, 3))
                0: send_word(OP_LOOKUP, fill_first[idx], fill_second[idx], '0);
                1: send_word(OP_SET, fill_first[idx], fill_second[idx], rand_val());
                2: send_word(OP_SET, rand_cp(), rand_cp(), rand_val());
                default: begin
                    idx = $urandom_range(DEPTH, FILL_WORDS - 1);
                    send_word(OP_LOOKUP, fill_first[idx], fill_second[idx], rand_val());
                end
            endcase
        end
        wait_drained();

        // tail without idling on either side
        quiet_tail <= 1'b1;
        send_word(OP_CLEAR, '0, '0, '0);
        mixed_words(100);
        wait_drained();

        // room for a late stray word, even after a shift across the whole table
        repeat (300) @(posedge aclk);
        if (mismatch_count == 0 && pending_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    // guard against a hung handshake
    initial begin
        #10_000_000;
        $display("Verification failed");
        $finish;
    end

endmodule
